@@ sv/assert_macros.svh @@
// Assertion macros for the lowest common ancestor block.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lca_pkg.sv @@
// Shared types and constants of the lowest common ancestor block.
// Used by lca_ctrl, lca_datapath and lowest_common_ancestor.
package lca_pkg;

  localparam int MAX_NODES_DEF = 65536;
  localparam int LEVELS_DEF    = 16;
  localparam int NODE_FW       = 17;   // width of a node field
  localparam int IN_DW         = 40;   // two node fields, padded to bytes
  localparam int OUT_DW        = 24;
  localparam int K_W           = 5;    // level counter, enough for 20 levels

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_DEPTH_A,
    DP_DEPTH_B,
    DP_ADD_ROOT,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_SWAP,
    DP_LIFT_RD,
    DP_LIFT_WR,
    DP_JUMP_RD,
    DP_JUMP_WR,
    DP_PAR_RD,
    DP_RES_A,
    DP_RES_PAR,
    DP_RES_BAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [K_W-1:0]   k;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_query;
    logic diff_bit;
    logic a_eq_b;
    logic rows_differ;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ sv/lca_datapath.sv @@
// Datapath: node count, depth memory, ancestor table and the output register.
// Driven by lca_ctrl through lca_pkg::dp_cmd_t; reports lca_pkg::dp_sts_t.
module lca_datapath #(
  parameter int MAX_NODES = lca_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lca_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lca_pkg::IN_DW-1:0] in_tdata,
  input  logic                      in_tuser,
  input  lca_pkg::dp_cmd_t          cmd,
  output lca_pkg::dp_sts_t          sts,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [lca_pkg::OUT_DW-1:0] out_tdata,
  output logic                      out_tuser
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW = NW + LW;
  localparam int FW = lca_pkg::NODE_FW;

  logic [NW-1:0] tbl_mem [0:(1<<AW)-1];
  logic [NW-1:0] dep_mem [0:MAX_NODES-1];

  logic              op_r, bad_r;
  logic [NW-1:0]     a_r, b_r, t_r, da_r;
  logic [CW-1:0]     cnt_r;
  logic [LEVELS-1:0] diff_r;
  logic [NW-1:0]     ta_q_r, tb_q_r, dep_q_r;
  logic              ta_root_r, tb_root_r, dep_root_r;
  logic              out_valid_r, out_bad_r;
  logic [FW-1:0]     out_node_r;

  logic [FW-1:0]     f_in, s_in;
  logic [31:0]       f32, s32, cnt32;
  logic              add_bad, qry_bad;
  logic [NW-1:0]     anc_a, anc_b, dep_val;
  logic [LW-1:0]     lvl, lvl_m1;
  logic              ra_en, rb_en, dep_en, tw_en;
  logic [NW-1:0]     ra_node, dep_addr;
  logic [AW-1:0]     tw_addr;
  logic [NW-1:0]     tw_data;
  logic              out_busy;
  logic [31:0]       diff32;

  assign f_in  = in_tdata[FW-1:0];
  assign s_in  = in_tdata[2*FW-1:FW];
  assign f32   = 32'(f_in);
  assign s32   = 32'(s_in);
  assign cnt32 = 32'(cnt_r);
  assign add_bad = (f32 < 32'd1) || (f32 > cnt32) || (cnt32 >= 32'(MAX_NODES)) ||
                   (s32 != cnt32 + 32'd1);
  assign qry_bad = (f32 < 32'd1) || (f32 > cnt32) || (s32 < 32'd1) || (s32 > cnt32);

  // root row and root depth are zero without ever being stored
  assign anc_a   = ta_root_r  ? '0 : ta_q_r;
  assign anc_b   = tb_root_r  ? '0 : tb_q_r;
  assign dep_val = dep_root_r ? '0 : dep_q_r;

  assign lvl    = cmd.k[LW-1:0];
  assign lvl_m1 = LW'(cmd.k - lca_pkg::K_W'(1));
  assign out_busy = out_valid_r && !out_tready;
  assign diff32 = (da_r < dep_val) ? 32'(dep_val - da_r) : 32'(da_r - dep_val);

  always_comb begin
    ra_en    = 1'b0;
    rb_en    = 1'b0;
    dep_en   = 1'b0;
    tw_en    = 1'b0;
    ra_node  = a_r;
    dep_addr = a_r;
    tw_addr  = {b_r, lvl};
    tw_data  = anc_a;
    case (cmd.op)
      lca_pkg::DP_DEPTH_A: dep_en = 1'b1;
      lca_pkg::DP_DEPTH_B: begin
        dep_en   = 1'b1;
        dep_addr = b_r;
      end
      lca_pkg::DP_ADD_ROOT: begin
        tw_en   = 1'b1;
        tw_addr = {b_r, LW'(0)};
        tw_data = a_r;
      end
      lca_pkg::DP_ADD_RD: begin
        ra_en   = 1'b1;
        ra_node = t_r;
      end
      lca_pkg::DP_ADD_WR:  tw_en = 1'b1;
      lca_pkg::DP_LIFT_RD: ra_en = 1'b1;
      lca_pkg::DP_JUMP_RD: begin
        ra_en = 1'b1;
        rb_en = 1'b1;
      end
      lca_pkg::DP_PAR_RD:  ra_en = 1'b1;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (tw_en) tbl_mem[tw_addr] <= tw_data;
    if (cmd.op == lca_pkg::DP_ADD_ROOT) dep_mem[b_r] <= dep_val + NW'(1);
    if (ra_en) begin
      ta_q_r    <= tbl_mem[{ra_node, (cmd.op == lca_pkg::DP_ADD_RD) ? lvl_m1 :
                                     (cmd.op == lca_pkg::DP_PAR_RD) ? LW'(0) : lvl}];
      ta_root_r <= (ra_node == '0);
    end
    if (rb_en) begin
      tb_q_r    <= tbl_mem[{b_r, lvl}];
      tb_root_r <= (b_r == '0);
    end
    if (dep_en) begin
      dep_q_r    <= dep_mem[dep_addr];
      dep_root_r <= (dep_addr == '0);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lca_pkg::DP_LOAD: begin
        op_r  <= in_tuser;
        bad_r <= (in_tuser == lca_pkg::OP_ADD) ? add_bad : qry_bad;
        a_r   <= NW'(f32 - 32'd1);
        b_r   <= NW'(s32 - 32'd1);
      end
      lca_pkg::DP_DEPTH_B:  da_r <= dep_val;
      lca_pkg::DP_ADD_ROOT: t_r <= a_r;
      lca_pkg::DP_ADD_WR:   t_r <= anc_a;
      lca_pkg::DP_SWAP: begin
        diff_r <= diff32[LEVELS-1:0];
        if (da_r < dep_val) begin
          a_r <= b_r;
          b_r <= a_r;
        end
      end
      lca_pkg::DP_LIFT_WR: a_r <= anc_a;
      lca_pkg::DP_JUMP_WR: begin
        if (anc_a != anc_b) begin
          a_r <= anc_a;
          b_r <= anc_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == lca_pkg::DP_ADD_ROOT) cnt_r <= cnt_r + CW'(1);
      if (cmd.op == lca_pkg::DP_RES_A || cmd.op == lca_pkg::DP_RES_PAR ||
          cmd.op == lca_pkg::DP_RES_BAD) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lca_pkg::DP_RES_A: begin
        out_node_r <= FW'(32'(a_r) + 32'd1);
        out_bad_r  <= 1'b0;
      end
      lca_pkg::DP_RES_PAR: begin
        out_node_r <= FW'(32'(anc_a) + 32'd1);
        out_bad_r  <= 1'b0;
      end
      lca_pkg::DP_RES_BAD: begin
        out_node_r <= '0;
        out_bad_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.bad         = bad_r;
  assign sts.is_query    = op_r;
  assign sts.diff_bit    = diff_r[lvl];
  assign sts.a_eq_b      = (a_r == b_r);
  assign sts.rows_differ = (anc_a != anc_b);
  assign sts.out_busy    = out_busy;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lca_pkg::OUT_DW'(out_node_r);
  assign out_tuser  = out_bad_r;

endmodule

@@ sv/lca_ctrl.sv @@
// Controller: sequences table fill on add and the two lifting phases on query.
// Talks to lca_datapath through the command and status types of lca_pkg.
module lca_ctrl #(
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  lca_pkg::dp_sts_t sts,
  output lca_pkg::dp_cmd_t cmd
);

  localparam logic [lca_pkg::K_W-1:0] KTOP = lca_pkg::K_W'(LEVELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_BAD, S_DEPA, S_ADD0, S_ADDRD, S_ADDWR, S_DEPB,
    S_SWAP, S_LIFT, S_LIFTWR, S_CMP, S_RESA, S_JRD, S_JWR, S_PRD
  } state_t;

  state_t                  state_r, state_nxt;
  logic [lca_pkg::K_W-1:0] k_r, k_nxt;
  logic                    pres_r, pres_nxt;   // parent read done, result pending

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pres_nxt  = pres_r;
    cmd.op    = lca_pkg::DP_NONE;
    cmd.k     = k_r;
    case (state_r)
      S_IDLE: begin
        if (pres_r) begin
          if (!sts.out_busy) begin
            cmd.op   = lca_pkg::DP_RES_PAR;
            pres_nxt = 1'b0;
          end
        end else if (in_tvalid) begin
          cmd.op    = lca_pkg::DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = sts.bad ? S_BAD : S_DEPA;
      S_BAD: begin
        if (!sts.out_busy) begin
          cmd.op    = lca_pkg::DP_RES_BAD;
          state_nxt = S_IDLE;
        end
      end
      S_DEPA: begin
        cmd.op    = lca_pkg::DP_DEPTH_A;
        state_nxt = sts.is_query ? S_DEPB : S_ADD0;
      end
      S_ADD0: begin
        cmd.op    = lca_pkg::DP_ADD_ROOT;
        k_nxt     = lca_pkg::K_W'(1);
        state_nxt = (LEVELS == 1) ? S_IDLE : S_ADDRD;
      end
      S_ADDRD: begin
        cmd.op    = lca_pkg::DP_ADD_RD;
        state_nxt = S_ADDWR;
      end
      S_ADDWR: begin
        cmd.op = lca_pkg::DP_ADD_WR;
        if (k_r == KTOP) state_nxt = S_IDLE;
        else begin
          k_nxt     = k_r + lca_pkg::K_W'(1);
          state_nxt = S_ADDRD;
        end
      end
      S_DEPB: begin
        cmd.op    = lca_pkg::DP_DEPTH_B;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd.op    = lca_pkg::DP_SWAP;
        k_nxt     = '0;
        state_nxt = S_LIFT;
      end
      S_LIFT: begin
        if (sts.diff_bit) begin
          cmd.op    = lca_pkg::DP_LIFT_RD;
          state_nxt = S_LIFTWR;
        end else if (k_r == KTOP) state_nxt = S_CMP;
        else k_nxt = k_r + lca_pkg::K_W'(1);
      end
      S_LIFTWR: begin
        cmd.op = lca_pkg::DP_LIFT_WR;
        if (k_r == KTOP) state_nxt = S_CMP;
        else begin
          k_nxt     = k_r + lca_pkg::K_W'(1);
          state_nxt = S_LIFT;
        end
      end
      S_CMP: begin
        if (sts.a_eq_b) state_nxt = S_RESA;
        else begin
          k_nxt     = KTOP;
          state_nxt = S_JRD;
        end
      end
      S_RESA: begin
        if (!sts.out_busy) begin
          cmd.op    = lca_pkg::DP_RES_A;
          state_nxt = S_IDLE;
        end
      end
      S_JRD: begin
        cmd.op    = lca_pkg::DP_JUMP_RD;
        state_nxt = S_JWR;
      end
      S_JWR: begin
        cmd.op = lca_pkg::DP_JUMP_WR;
        if (k_r == '0) state_nxt = S_PRD;
        else begin
          k_nxt     = k_r - lca_pkg::K_W'(1);
          state_nxt = S_JRD;
        end
      end
      S_PRD: begin
        cmd.op    = lca_pkg::DP_PAR_RD;
        cmd.k     = '0;
        pres_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      pres_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pres_r  <= pres_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE) && !pres_r;

endmodule

@@ sv/lowest_common_ancestor.sv @@
// Lowest common ancestor by binary lifting on a tree grown one leaf at a time.
// Holds lca_ctrl and lca_datapath; uses lca_pkg and assert_macros.svh.

// Node 1 is the root. operation 0 (tuser low) adds node count+1 under the parent
// in first_node and gives no result unless refused; operation 1 queries two
// present nodes. Refused items give ancestor 0 with the bad flag. One item is
// worked at a time and all its work goes through the ancestor table, one read
// port pair per cycle. No clearing pass is needed after reset.
`include "assert_macros.svh"

module lowest_common_ancestor #(
  parameter int MAX_NODES = lca_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lca_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lca_pkg::IN_DW-1:0]  in_tdata,   // first_node[16:0], second_node[33:17]
  input  logic                       in_tuser,   // operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lca_pkg::OUT_DW-1:0] out_tdata,  // ancestor_node[16:0]
  output logic                       out_tuser   // bad_request
);

  lca_pkg::dp_cmd_t cmd;
  lca_pkg::dp_sts_t sts;

  lca_ctrl #(.LEVELS(LEVELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lca_datapath #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `ASSERT_IMPLIES(a_bad_zero, out_tvalid && out_tuser, out_tdata == '0, "bad result not zero")
  `ASSERT_IMPLIES(a_good_nonzero, out_tvalid && !out_tuser, out_tdata != '0, "zero ancestor")

endmodule

@@ tb/tb.sv @@
// Testbench for lowest_common_ancestor: random tree growth and ancestor queries.
// Depends on lca_pkg and the lowest_common_ancestor RTL; checks via a scoreboard class.
`timescale 1ns / 100ps

module tb;

  localparam int MAXN = 65536;
  localparam int WATCHDOG = 20000;

  class lca_scoreboard;
    int unsigned node_total;
    int unsigned depth_of[int unsigned];
    int unsigned parent_of[int unsigned];
    logic [16:0] expected_anc[$];
    logic        expected_bad[$];
    int          errors;

    function new();
      node_total = 1;
      depth_of[1] = 0;
      parent_of[1] = 1;
      errors = 0;
    endfunction

    function void queue_expected(logic [16:0] a, logic b);
      expected_anc = {expected_anc, a};
      expected_bad = {expected_bad, b};
    endfunction

    // the tree only grows by leaves, so walking parents gives the exact answer
    function int unsigned common_ancestor(int unsigned a, int unsigned b);
      int unsigned t;
      if (depth_of[a] < depth_of[b]) begin
        t = a; a = b; b = t;
      end
      while (depth_of[a] > depth_of[b]) a = parent_of[a];
      while (a != b) begin
        a = parent_of[a];
        b = parent_of[b];
      end
      return a;
    endfunction

    function void note_item(logic op, int unsigned f, int unsigned s);
      if (op == lca_pkg::OP_ADD) begin
        if (f < 1 || f > node_total || node_total >= MAXN || s != node_total + 1) begin
          queue_expected(17'd0, 1'b1);
        end else begin
          depth_of[s] = depth_of[f] + 1;
          parent_of[s] = f;
          node_total++;
        end
      end else if (f < 1 || f > node_total || s < 1 || s > node_total) begin
        queue_expected(17'd0, 1'b1);
      end else begin
        queue_expected(17'(common_ancestor(f, s)), 1'b0);
      end
    endfunction

    function void check_result(logic [lca_pkg::OUT_DW-1:0] data, logic bad);
      logic [16:0] ea;
      logic eb;
      if (expected_anc.size() == 0) begin
        $display("%0t: unexpected result anc=%0d bad=%0b", $time, data[16:0], bad);
        errors++;
        return;
      end
      ea = expected_anc.pop_front();
      eb = expected_bad.pop_front();
      if (data[16:0] !== ea) begin
        $display("%0t: ancestor mismatch expected %0d actual %0d", $time, ea, data[16:0]);
        errors++;
      end
      if (data[lca_pkg::OUT_DW-1:17] !== '0) begin
        $display("%0t: padding mismatch expected 0 actual %0h", $time,
                 data[lca_pkg::OUT_DW-1:17]);
        errors++;
      end
      if (bad !== eb) begin
        $display("%0t: bad flag mismatch expected %0b actual %0b", $time, eb, bad);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lca_pkg::IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lca_pkg::OUT_DW-1:0] out_tdata;
  logic out_tuser;

  lca_scoreboard lca_sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  bit stim_done = 0;
  bit hold_done = 0;

  lowest_common_ancestor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one transaction; valid stays high within a burst, gaps come between bursts
  task automatic send_item(logic op, int unsigned f, int unsigned s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b0, 17'(s), 17'(f)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lca_sb.note_item(op, f, s);
    @(negedge clk);
  endtask

  task automatic add_random();
    int unsigned n;
    n = lca_sb.node_total;
    // mostly deep chains of recent nodes, sometimes anywhere
    if ($urandom_range(0, 2) == 0) send_item(lca_pkg::OP_ADD, $urandom_range(1, n), n + 1);
    else send_item(lca_pkg::OP_ADD, n - $urandom_range(0, n > 4 ? 4 : n - 1), n + 1);
  endtask

  task automatic random_item();
    int unsigned n;
    int r;
    n = lca_sb.node_total;
    r = $urandom_range(0, 99);
    if (r < 45) add_random();
    else if (r < 88)
      send_item(lca_pkg::OP_QUERY, $urandom_range(1, n), $urandom_range(1, n));
    else if (r < 94)
      send_item(lca_pkg::OP_ADD, $urandom_range(0, 131071), $urandom_range(0, 131071));
    else
      send_item(lca_pkg::OP_QUERY, $urandom_range(0, 131071), $urandom_range(0, 131071));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed part
    send_item(lca_pkg::OP_QUERY, 1, 1);
    send_item(lca_pkg::OP_QUERY, 0, 1);
    send_item(lca_pkg::OP_QUERY, 1, 2);
    send_item(lca_pkg::OP_QUERY, 131071, 131071);
    send_item(lca_pkg::OP_ADD, 0, 2);
    send_item(lca_pkg::OP_ADD, 2, 2);
    send_item(lca_pkg::OP_ADD, 1, 3);
    send_item(lca_pkg::OP_ADD, 131071, 2);
    send_item(lca_pkg::OP_ADD, 1, 2);
    send_item(lca_pkg::OP_ADD, 2, 3);
    send_item(lca_pkg::OP_ADD, 1, 4);
    send_item(lca_pkg::OP_ADD, 3, 5);
    send_item(lca_pkg::OP_QUERY, 5, 4);
    send_item(lca_pkg::OP_QUERY, 3, 5);
    send_item(lca_pkg::OP_QUERY, 5, 5);
    send_item(lca_pkg::OP_QUERY, 2, 1);
    send_item(lca_pkg::OP_QUERY, 6, 2);
    send_item(lca_pkg::OP_ADD, 6, 6);
    for (int i = 0; i < 600; i++) random_item();
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  // receiver stall pattern, with one long hold-off early on
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && lca_sb.node_total > 30) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      if ($urandom_range(0, 199) < 3) repeat ($urandom_range(1, 40)) @(negedge clk);
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) lca_sb.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done && lca_sb.expected_anc.size() == 0);
    repeat (200) @(posedge clk);
    if (lca_sb.errors == 0 && lca_sb.expected_anc.size() == 0)
      $display("** lowest_common_ancestor: PASSED **");
    else
      $display("** lowest_common_ancestor: FAILED **");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("%0t: watchdog expired", $time);
    $display("** lowest_common_ancestor: FAILED **");
    $finish;
  end
endmodule
